// ===== hw/rtl/ppp_pkg.sv =====
// Shared types, constants and helpers of the pixel projection profile unit.
`default_nettype none

package ppp_pkg;

    localparam int PIX_W       = 8;
    localparam int POS_W       = 10;
    localparam int COUNT_W     = 11;
    localparam int CFG_W       = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int FIFO_DEPTH  = 3;
    localparam int FIFO_PTR_W  = 2;

    localparam logic [PIX_W-1:0]   WHITE     = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        KIND_ROW  = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        kind_t              kind;
        logic [POS_W-1:0]   pos;
        logic [COUNT_W-1:0] count;
        logic               frame_done;
    } res_t;

    // Increment that sticks at the largest count.
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ppp_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module ppp_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read of the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pixel_projection_profile_unit.sv =====
// Top level of the pixel projection profile unit: row and column profiles of a grey image.
//
//  Channel  | Signals                               | Contents
//  ---------+---------------------------------------+---------------------------------------
//  s_axis   | tvalid tready tdata[23:0] tuser[0]    | pixel or column read request
//  m_axis   | tvalid tready tdata[23:0] tuser tlast | row count or column count result
//  cfg      | valid ready index[0] data[10:0]       | image_width (0), image_height (1)
//
//  One transaction is taken per clock while the result queue has room.
//  The column store is a one-port-write, one-port-read RAM; each pixel reads its
//  column, and the word is updated and written back in the next cycle, with the
//  just-written word forwarded when the next request hits the same column.
//  Reset clears positions, the row tally and the result queue; the store is never
//  cleared because the first row of each frame overwrites it.
//  A stalled m_axis fills a three-entry result queue, after which s_axis is held off.
`default_nettype none

module pixel_projection_profile_unit
    import ppp_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: pixel_value [7:0], column_to_read [17:8], zero padding [23:18]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: operation [0]
    input  wire logic                   s_axis_tuser,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: position [9:0], count [20:10], zero padding [23:21]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: result_kind [0]
    output logic                        m_axis_tuser,
    // tlast: frame_done
    output logic                        m_axis_tlast,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic                   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int CW      = $clog2(MAX_COLS);
    localparam int RW      = $clog2(MAX_ROWS);
    localparam int W_RESET = (1024 < MAX_COLS) ? 1024 : MAX_COLS;
    localparam int H_RESET = (1024 < MAX_ROWS) ? 1024 : MAX_ROWS;

    // ------------------------------------------------------------------
    // Configuration: the clamped dimension is stored as its last index.
    // ------------------------------------------------------------------
    logic [CW-1:0] w_last_reg, w_last_next;
    logic [RW-1:0] h_last_reg, h_last_next;
    logic [31:0]   cfg_val32;
    logic          cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_val32 = {{(32 - CFG_W){1'b0}}, cfg_data};

    always_comb
    begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:
                begin
                    if (cfg_val32 == 32'd0)
                        w_last_next = '0;
                    else if (cfg_val32 > 32'(MAX_COLS))
                        w_last_next = CW'(MAX_COLS - 1);
                    else
                        w_last_next = CW'(cfg_val32 - 32'd1);
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (cfg_val32 == 32'd0)
                        h_last_next = '0;
                    else if (cfg_val32 > 32'(MAX_ROWS))
                        h_last_next = RW'(MAX_ROWS - 1);
                    else
                        h_last_next = RW'(cfg_val32 - 32'd1);
                end
                default:
                begin
                    w_last_next = w_last_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request stage: raster position and row tally live in registers.
    // ------------------------------------------------------------------
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [COUNT_W-1:0] tally_reg, tally_next;

    logic               in_accept;
    op_t                in_op;
    logic [PIX_W-1:0]   in_pix;
    logic [POS_W-1:0]   in_rcol;
    logic [CW+POS_W-1:0] rcol_ext;
    logic               in_range;
    logic               below;
    logic [COUNT_W-1:0] tally_inc;
    logic               row_end;
    logic               last_row;
    logic [RW+POS_W-1:0] row_wide;
    logic [CW-1:0]      rd_addr;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_op     = op_t'(s_axis_tuser);
    assign in_pix    = s_axis_tdata[PIX_W-1:0];
    assign in_rcol   = s_axis_tdata[PIX_W+POS_W-1:PIX_W];
    assign rcol_ext  = {{CW{1'b0}}, in_rcol};
    // Reads past the store answer zero; the address wraps harmlessly.
    assign in_range  = rcol_ext < (CW+POS_W)'(MAX_COLS);
    assign below     = in_pix != WHITE;
    assign tally_inc = (in_pix == '0) ? sat_inc(tally_reg) : tally_reg;
    assign row_end   = col_reg >= w_last_reg;
    assign last_row  = row_reg >= h_last_reg;
    assign row_wide  = {{POS_W{1'b0}}, row_reg};
    assign rd_addr   = (in_op == OP_PIXEL) ? col_reg : rcol_ext[CW-1:0];

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        tally_next = tally_reg;
        if (in_accept && (in_op == OP_PIXEL))
        begin
            if (row_end)
            begin
                col_next   = '0;
                tally_next = '0;
                row_next   = last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next   = col_reg + CW'(1);
                tally_next = tally_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Update stage: read data is back; modify the column word and write it.
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic [CW-1:0]      s1_addr_reg;
    logic               s1_below_reg;
    logic               s1_first_reg;
    logic               s1_row_end_reg;
    logic               s1_in_range_reg;
    logic               s1_frame_done_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic [COUNT_W-1:0] s1_row_count_reg;
    logic               fwd_hit_reg;
    logic [COUNT_W-1:0] fwd_data_reg;

    logic [COUNT_W-1:0] ram_rd_data;
    logic [COUNT_W-1:0] old_val;
    logic [COUNT_W-1:0] new_val;
    logic               ram_we;
    logic               fwd_hit_next;
    logic               push;
    res_t               push_res;

    assign old_val = fwd_hit_reg ? fwd_data_reg : ram_rd_data;

    always_comb
    begin
        if (s1_first_reg)
            new_val = {{(COUNT_W - 1){1'b0}}, s1_below_reg};
        else if (s1_below_reg)
            new_val = sat_inc(old_val);
        else
            new_val = old_val;
    end

    assign ram_we       = s1_valid_reg && (s1_op_reg == OP_PIXEL);
    // The word being written now is not yet visible to a read issued now.
    assign fwd_hit_next = ram_we && (s1_addr_reg == rd_addr);
    assign push         = s1_valid_reg && ((s1_op_reg == OP_READ) || s1_row_end_reg);

    always_comb
    begin
        if (s1_op_reg == OP_READ)
        begin
            push_res.kind       = KIND_READ;
            push_res.pos        = s1_pos_reg;
            push_res.count      = s1_in_range_reg ? old_val : '0;
            push_res.frame_done = 1'b0;
        end
        else
        begin
            push_res.kind       = KIND_ROW;
            push_res.pos        = s1_pos_reg;
            push_res.count      = s1_row_count_reg;
            push_res.frame_done = s1_frame_done_reg;
        end
    end

    ppp_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_COLS)
    ) u_col_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (s1_addr_reg),
        .wr_data (new_val),
        .re      (in_accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Result queue: decouples the output handshake from the pipeline.
    // ------------------------------------------------------------------
    res_t                  fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W-1:0] cnt_reg, cnt_next;
    logic [FIFO_PTR_W:0]   occupancy;
    logic                  pop;
    res_t                  head;

    assign occupancy     = {1'b0, cnt_reg} + {{FIFO_PTR_W{1'b0}}, s1_valid_reg};
    assign s_axis_tready = occupancy < (FIFO_PTR_W+1)'(FIFO_DEPTH);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign head          = fifo_mem_reg[rd_ptr_reg];

    assign m_axis_tvalid = cnt_reg != '0;
    assign m_axis_tdata  = {{(OUT_TDATA_W - POS_W - COUNT_W){1'b0}}, head.count, head.pos};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.frame_done;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (push && !pop)
            cnt_next = cnt_reg + FIFO_PTR_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - FIFO_PTR_W'(1);
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg   <= CW'(W_RESET - 1);
            h_last_reg   <= RW'(H_RESET - 1);
            col_reg      <= '0;
            row_reg      <= '0;
            tally_reg    <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            w_last_reg   <= w_last_next;
            h_last_reg   <= h_last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            tally_reg    <= tally_next;
            s1_valid_reg <= in_accept;
            fwd_hit_reg  <= in_accept && fwd_hit_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            cnt_reg      <= cnt_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg         <= in_op;
            s1_addr_reg       <= rd_addr;
            s1_below_reg      <= below;
            s1_first_reg      <= row_reg == '0;
            s1_row_end_reg    <= row_end;
            s1_in_range_reg   <= in_range;
            s1_frame_done_reg <= last_row;
            s1_pos_reg        <= (in_op == OP_PIXEL) ? row_wide[POS_W-1:0] : in_rcol;
            s1_row_count_reg  <= tally_inc;
            fwd_data_reg      <= new_val;
        end
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= push_res;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((cnt_reg != FIFO_PTR_W'(FIFO_DEPTH)) || pop))
        else $error("result queue written while full");

    a_fwd_pairs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> (s1_valid_reg && $past(ram_we)))
        else $error("forwarded word without a matching update");

    a_frame_on_row: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_ROW))
        else $error("frame end flagged on a column read result");

    a_col_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= CW'(MAX_COLS - 1))
        else $error("column position beyond store");

    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_op == OP_PIXEL) && row_end && last_row) |=>
            ((row_reg == '0) && (col_reg == '0) && (tally_reg == '0)))
        else $error("frame end did not restart the raster position");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench of the pixel projection profile unit.
`timescale 1ns / 100ps

module testbench;
    import ppp_pkg::*;

    // The block is built with its default store sizes.
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    // The settle wait after the last result covers the store write-back of pixels
    // that end no row.
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 40;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;

    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // tdata: pixel_value [7:0], column_to_read [17:8], zero padding [23:18]
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // tuser: operation [0]
    logic                    s_axis_tuser = 1'b0;

    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // tdata: position [9:0], count [20:10], zero padding [23:21]
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    // tuser: result_kind [0]
    logic                    m_axis_tuser;
    // tlast: frame_done
    logic                    m_axis_tlast;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic                    cfg_index = 1'b0;
    logic [CFG_W-1:0]        cfg_data = '0;

    pixel_projection_profile_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Idle behavior of both sides. Each transaction draws a wait from zero up to
    // these bounds; the tests change them to get busy stretches and sparse ones.
    int tx_max_gap     = 15;
    int rx_max_stall   = 15;
    // A nonzero value asks the result sink for one long hold-off of that many cycles.
    int rx_hold_cycles = 0;

    int error_count = 0;
    int cycle_count = 0;

    // ------------------------------------------------------------------------
    // Profile predictor: a private copy of the registers, the raster position,
    // the row tally of zero pixels and the column store of non-white counts.
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]   width_reg  = 11'd1024;
    logic [CFG_W-1:0]   height_reg = 11'd1024;
    logic [POS_W-1:0]   next_col   = '0;
    logic [POS_W-1:0]   next_row   = '0;
    logic [COUNT_W-1:0] zero_run_tally = '0;
    logic [COUNT_W-1:0] col_profile [MAX_COLS];

    // Row and column counts still owed by the block, oldest first.
    res_t profile_results [$];

    // A register value of zero acts as one, and a value past the store size acts
    // as the store size.
    function automatic int clamp_extent(input logic [CFG_W-1:0] v, input int limit);
        if (v == '0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    // Counts stick at their largest value instead of wrapping.
    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    task automatic predict_profile(input op_t op, input logic [PIX_W-1:0] pix,
                                   input logic [POS_W-1:0] rcol);
        res_t r;
        int   w;
        int   h;
        int   c;
        bit   non_white;
        bit   frame_end;
        if (op == OP_READ)
        begin
            r.kind       = KIND_READ;
            r.pos        = rcol;
            r.count      = col_profile[rcol];
            r.frame_done = 1'b0;
            profile_results = {profile_results, r};
            return;
        end
        w = clamp_extent(width_reg, MAX_COLS);
        h = clamp_extent(height_reg, MAX_ROWS);
        c = int'(next_col);
        non_white = (pix != WHITE);
        // The first row of a frame overwrites the store; later rows add to it.
        if (next_row == '0)
            col_profile[c] = COUNT_W'(non_white);
        else if (non_white)
            col_profile[c] = bump(col_profile[c]);
        if (pix == '0)
            zero_run_tally = bump(zero_run_tally);
        // A row ends at the first pixel at or past the last column in use, which
        // also covers a width that shrank in the middle of a row.
        if (c + 1 >= w)
        begin
            frame_end    = (int'(next_row) + 1 >= h);
            r.kind       = KIND_ROW;
            r.pos        = next_row;
            r.count      = zero_run_tally;
            r.frame_done = frame_end;
            profile_results = {profile_results, r};
            zero_run_tally = '0;
            next_col       = '0;
            next_row       = frame_end ? '0 : next_row + 1'b1;
        end
        else
        begin
            next_col = next_col + 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus side. One task sends a single item; it leaves tvalid high so that
    // back-to-back transactions need no second assignment in one time step.
    // ------------------------------------------------------------------------
    task automatic send_item(input op_t op, input logic [PIX_W-1:0] pix,
                             input logic [POS_W-1:0] rcol);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_TDATA_W'({rcol, pix});
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_profile(op, pix, rcol);
    endtask

    // Stops offering items and waits until every owed result has been taken,
    // then lets the pipeline settle so that no store write-back is in flight.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (profile_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the block idle. Either register may be
    // skipped; cfg_valid stays high across two writes in a row.
    task automatic reconfigure(input bit set_w, input logic [CFG_W-1:0] w,
                               input bit set_h, input logic [CFG_W-1:0] h);
        drain_results();
        if (set_w)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_IMAGE_WIDTH;
            cfg_data  <= w;
            do
                @(posedge clk);
            while (!cfg_ready);
            width_reg = w;
        end
        if (set_h)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_IMAGE_HEIGHT;
            cfg_data  <= h;
            do
                @(posedge clk);
            while (!cfg_ready);
            height_reg = h;
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly pixels, with many black and white ones so that both counts move;
    // reads go either to the columns in use or anywhere in the store.
    task automatic send_random_item(input int width_now);
        op_t               op;
        logic [PIX_W-1:0]  pix;
        logic [POS_W-1:0]  rcol;
        int                pick;
        pick = $urandom_range(0, 99);
        op   = (pick < 20) ? OP_READ : OP_PIXEL;
        rcol = POS_W'($urandom_range(0, MAX_COLS - 1));
        if (pick < 10)
            rcol = POS_W'($urandom_range(0, width_now - 1));
        pick = $urandom_range(0, 3);
        if (pick == 0)
            pix = '0;
        else if (pick == 1)
            pix = WHITE;
        else
            pix = PIX_W'($urandom_range(0, 255));
        send_item(op, pix, rcol);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // One small frame with black, white, near-black and near-white pixels, then
    // reads of its columns. The last row closes the frame.
    task automatic test_small_frame();
        reconfigure(1'b1, 11'd4, 1'b1, 11'd3);
        send_item(OP_PIXEL, 8'd0,   '0);
        send_item(OP_PIXEL, 8'd255, '0);
        send_item(OP_PIXEL, 8'd254, '0);
        send_item(OP_PIXEL, 8'd1,   '0);
        send_item(OP_PIXEL, 8'd0,   '0);
        send_item(OP_PIXEL, 8'd0,   '0);
        send_item(OP_PIXEL, 8'd128, '0);
        send_item(OP_PIXEL, 8'd255, '0);
        send_item(OP_PIXEL, 8'd255, '0);
        send_item(OP_PIXEL, 8'h55,  '0);
        send_item(OP_PIXEL, 8'hAA,  '0);
        send_item(OP_PIXEL, 8'd0,   '0);
        send_item(OP_READ,  8'd0,   10'd0);
        send_item(OP_READ,  8'hFF,  10'd1);
        send_item(OP_READ,  8'd0,   10'd3);
    endtask

    // Register values of zero and of all ones, and registers changed in the
    // middle of a row and of a frame.
    task automatic test_register_edges();
        // Zero width and height act as one: every pixel is a row and a frame.
        reconfigure(1'b1, 11'd0, 1'b1, 11'd0);
        send_item(OP_PIXEL, 8'd0,   '0);
        send_item(OP_PIXEL, 8'd255, '0);
        send_item(OP_READ,  8'd0,   10'd0);
        // All ones act as the full store; three pixels end no row.
        reconfigure(1'b1, 11'h7FF, 1'b1, 11'h7FF);
        send_item(OP_PIXEL, 8'd0,  '0);
        send_item(OP_PIXEL, 8'd7,  '0);
        send_item(OP_PIXEL, 8'd0,  '0);
        // Width shrinks below the current column: the next pixel ends the row.
        reconfigure(1'b1, 11'd2, 1'b0, '0);
        send_item(OP_PIXEL, 8'd0, '0);
        // Height shrinks below the current row: the next row end closes the frame.
        reconfigure(1'b0, '0, 1'b1, 11'd0);
        send_item(OP_PIXEL, 8'd200, '0);
        send_item(OP_PIXEL, 8'd0,   '0);
        // Column 3 now lies beyond the width and keeps its old count.
        send_item(OP_READ, 8'd0, 10'd3);
    endtask

    // A full-width row of black pixels: the largest row count, and every column
    // of the store written, so that reads can reach the far end of the store.
    task automatic test_full_width_row();
        tx_max_gap = 2;
        reconfigure(1'b1, 11'd1024, 1'b1, 11'd2);
        repeat (MAX_COLS)
            send_item(OP_PIXEL, 8'd0, POS_W'($urandom_range(0, MAX_COLS - 1)));
        tx_max_gap = 15;
        send_item(OP_READ, 8'd0, 10'd1023);
        send_item(OP_READ, 8'd0, 10'd512);
        send_item(OP_READ, 8'd0, 10'h2AA);
        send_item(OP_READ, 8'd0, 10'h155);
    endtask

    // The sink holds off for a long stretch while items keep coming, so the
    // result queue fills and the input stalls. Afterwards the sender pauses until
    // every result is back, then carries on.
    task automatic test_result_backpressure();
        reconfigure(1'b1, 11'd3, 1'b1, 11'd4);
        tx_max_gap     = 0;
        rx_hold_cycles = 300;
        repeat (24)
            send_random_item(3);
        repeat (7)
            send_item(OP_PIXEL, PIX_W'($urandom_range(0, 255)), '0);
        drain_results();
        repeat (10)
            send_random_item(3);
        tx_max_gap = 15;
    endtask

    // Random geometries, mostly whole small frames with reads mixed in, some cut
    // short so that the next register write lands in the middle of a frame.
    task automatic test_random_frames();
        int               sent;
        int               n;
        int               pick;
        int               eff_w;
        int               eff_h;
        bit               set_w;
        bit               set_h;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                w = '0;
            else if (pick == 1)
                w = 11'h7FF;
            else if (pick < 5)
                w = CFG_W'($urandom_range(13, 64));
            else
                w = CFG_W'($urandom_range(1, 12));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                h = '0;
            else if (pick == 1)
                h = 11'h7FF;
            else
                h = CFG_W'($urandom_range(1, 6));
            pick  = $urandom_range(0, 3);
            set_w = (pick != 1);
            set_h = (pick != 2);
            reconfigure(set_w, w, set_h, h);

            pick         = $urandom_range(0, 2);
            tx_max_gap   = (pick == 0) ? 0 : (pick == 1) ? 3 : 15;
            pick         = $urandom_range(0, 2);
            rx_max_stall = (pick == 0) ? 0 : (pick == 1) ? 3 : 15;

            eff_w = clamp_extent(width_reg, MAX_COLS);
            eff_h = clamp_extent(height_reg, MAX_ROWS);
            if (eff_w * eff_h <= 80 && $urandom_range(0, 9) < 7)
                n = eff_w * eff_h + eff_w * eff_h / 4;
            else
                n = $urandom_range(5, 40);
            repeat (n)
                send_random_item(eff_w);
            sent += n;
        end
        tx_max_gap   = 15;
        rx_max_stall = 15;
    endtask

    // ------------------------------------------------------------------------
    // Result side: the sink drives tready, the checker compares every
    // transaction with the oldest owed result.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
            begin
                stall = $urandom_range(0, rx_max_stall);
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin : result_checker
        res_t               want;
        logic [POS_W-1:0]   got_pos;
        logic [COUNT_W-1:0] got_count;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_pos   = m_axis_tdata[POS_W-1:0];
            got_count = m_axis_tdata[POS_W+COUNT_W-1:POS_W];
            if (profile_results.size() == 0)
            begin
                $error("unexpected result: kind %0d, position %0d, count %0d",
                       m_axis_tuser, got_pos, got_count);
                error_count++;
            end
            else
            begin
                want = profile_results.pop_front();
                if (m_axis_tuser !== want.kind)
                begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
                    error_count++;
                end
                if (got_pos !== want.pos)
                begin
                    $error("position: expected %0d, actual %0d", want.pos, got_pos);
                    error_count++;
                end
                if (got_count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, got_count);
                    error_count++;
                end
                if (m_axis_tlast !== want.frame_done)
                begin
                    $error("frame_done: expected %0d, actual %0d",
                           want.frame_done, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (col_profile[i])
            col_profile[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // The small directed tests run before the full-width row, so every pixel
        // in a later row of a frame lands on a column its first row wrote.
        test_small_frame();
        test_register_edges();
        test_full_width_row();
        test_result_backpressure();
        test_random_frames();
        drain_results();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== pixel_projection_profile_unit.f =====
hw/rtl/ppp_pkg.sv
hw/rtl/ppp_ram.sv
hw/rtl/pixel_projection_profile_unit.sv
dv/testbench.sv
